### rtl/mpsm_pkg.sv
// Package for the signature matcher: transaction types, rule ROM and class codes.
`timescale 1ns / 1ps

package mpsm_pkg;

   localparam int MAX_RULES       = 32;
   localparam int MAX_PATTERN_LEN = 16;
   localparam int RULE_COUNT      = 19;
   localparam int RULE_IDX_W      = 5;
   localparam int PAT_IDX_W       = $clog2(MAX_PATTERN_LEN);
   localparam int PAT_LEN_W       = $clog2(MAX_PATTERN_LEN + 1);

   // field kinds
   localparam logic [2:0] KIND_SNI     = 3'd0;
   localparam logic [2:0] KIND_DNS     = 3'd1;
   localparam logic [2:0] KIND_JA3     = 3'd2;
   localparam logic [2:0] KIND_SERVICE = 3'd3;
   localparam logic [2:0] KIND_APP     = 3'd4;

   // persona codes
   localparam logic [2:0] PERSONA_VOIP      = 3'd0;
   localparam logic [2:0] PERSONA_STREAMING = 3'd1;
   localparam logic [2:0] PERSONA_GAMING    = 3'd2;
   localparam logic [2:0] PERSONA_WORK      = 3'd3;
   localparam logic [2:0] PERSONA_IOT       = 3'd4;
   localparam logic [2:0] PERSONA_BULK      = 3'd5;

   // priority codes
   localparam logic [1:0] PRIO_HIGH   = 2'd0;
   localparam logic [1:0] PRIO_MEDIUM = 2'd1;
   localparam logic [1:0] PRIO_LOW    = 2'd2;

   // action codes
   localparam logic [1:0] ACTION_BOOST    = 2'd0;
   localparam logic [1:0] ACTION_OBSERVE  = 2'd1;
   localparam logic [1:0] ACTION_THROTTLE = 2'd2;

   // DSCP codepoints
   localparam logic [5:0] DSCP_EF   = 6'd46;
   localparam logic [5:0] DSCP_AF41 = 6'd34;
   localparam logic [5:0] DSCP_CS6  = 6'd48;
   localparam logic [5:0] DSCP_AF21 = 6'd18;
   localparam logic [5:0] DSCP_CS2  = 6'd16;
   localparam logic [5:0] DSCP_CS1  = 6'd8;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] text_byte;
      logic       byte_valid;
      logic       field_end;
      logic       request_end;
   } req_type;

   typedef struct packed {
      logic                  matched;
      logic [RULE_IDX_W-1:0] rule_index;
      logic [2:0]            persona_code;
      logic [1:0]            priority_code;
      logic [1:0]            action_code;
      logic [5:0]            dscp_value;
      logic [6:0]            confidence_pct;
   } rsp_type;

   localparam logic [2:0] RULE_KIND [RULE_COUNT] = '{
      KIND_SNI, KIND_SNI, KIND_SNI, KIND_JA3, KIND_SNI, KIND_SNI, KIND_SNI,
      KIND_SERVICE, KIND_SNI, KIND_SNI, KIND_APP, KIND_SNI, KIND_SNI,
      KIND_SERVICE, KIND_SERVICE, KIND_SNI, KIND_SNI, KIND_SNI, KIND_SERVICE
   };

   localparam logic [PAT_LEN_W-1:0] RULE_LEN [RULE_COUNT] = '{
      5'd7, 5'd15, 5'd11, 5'd15, 5'd11, 5'd10, 5'd7, 5'd6, 5'd3, 5'd8,
      5'd8, 5'd9, 5'd13, 5'd9, 5'd3, 5'd8, 5'd11, 5'd12, 5'd6
   };

   // patterns, already lower case, first character at index 0, zero padded
   localparam logic [7:0] RULE_TEXT [RULE_COUNT][MAX_PATTERN_LEN] = '{
      '{8'h7a, 8'h6f, 8'h6f, 8'h6d, 8'h2e, 8'h75, 8'h73, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h74, 8'h65, 8'h61, 8'h6d, 8'h73, 8'h2e, 8'h6d, 8'h69,
        8'h63, 8'h72, 8'h6f, 8'h73, 8'h6f, 8'h66, 8'h74, 8'h00},
      '{8'h6d, 8'h65, 8'h65, 8'h74, 8'h2e, 8'h67, 8'h6f, 8'h6f,
        8'h67, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h37, 8'h36, 8'h39, 8'h2c, 8'h34, 8'h39, 8'h31, 8'h39,
        8'h35, 8'h2d, 8'h34, 8'h39, 8'h31, 8'h39, 8'h39, 8'h00},
      '{8'h6e, 8'h65, 8'h74, 8'h66, 8'h6c, 8'h69, 8'h78, 8'h2e,
        8'h63, 8'h6f, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h64, 8'h69, 8'h73, 8'h6e, 8'h65, 8'h79, 8'h70, 8'h6c,
        8'h75, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h79, 8'h6f, 8'h75, 8'h74, 8'h75, 8'h62, 8'h65, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h74, 8'h77, 8'h69, 8'h74, 8'h63, 8'h68, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h70, 8'h73, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h78, 8'h62, 8'h6f, 8'h78, 8'h6c, 8'h69, 8'h76, 8'h65,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h66, 8'h6f, 8'h72, 8'h74, 8'h6e, 8'h69, 8'h74, 8'h65,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h69, 8'h6f, 8'h74, 8'h67, 8'h61, 8'h6d, 8'h65,
        8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h77, 8'h6f, 8'h72, 8'h6b, 8'h70, 8'h6c, 8'h61, 8'h63,
        8'h65, 8'h2e, 8'h63, 8'h6f, 8'h6d, 8'h00, 8'h00, 8'h00},
      '{8'h6f, 8'h66, 8'h66, 8'h69, 8'h63, 8'h65, 8'h33, 8'h36,
        8'h35, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h76, 8'h70, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6e, 8'h65, 8'h73, 8'h74, 8'h2e, 8'h63, 8'h6f, 8'h6d,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h74, 8'h70, 8'h6c, 8'h69, 8'h6e, 8'h6b, 8'h63, 8'h6c,
        8'h6f, 8'h75, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h75, 8'h70, 8'h64, 8'h61, 8'h74, 8'h65, 8'h2e, 8'h61,
        8'h70, 8'h70, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h62, 8'h61, 8'h63, 8'h6b, 8'h75, 8'h70, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [2:0] RULE_PERSONA [RULE_COUNT] = '{
      PERSONA_VOIP, PERSONA_VOIP, PERSONA_VOIP, PERSONA_VOIP,
      PERSONA_STREAMING, PERSONA_STREAMING, PERSONA_STREAMING, PERSONA_STREAMING,
      PERSONA_GAMING, PERSONA_GAMING, PERSONA_GAMING, PERSONA_GAMING,
      PERSONA_WORK, PERSONA_WORK, PERSONA_WORK,
      PERSONA_IOT, PERSONA_IOT, PERSONA_BULK, PERSONA_BULK
   };

   localparam logic [1:0] RULE_PRIO [RULE_COUNT] = '{
      PRIO_HIGH, PRIO_HIGH, PRIO_HIGH, PRIO_HIGH,
      PRIO_MEDIUM, PRIO_MEDIUM, PRIO_MEDIUM, PRIO_MEDIUM,
      PRIO_HIGH, PRIO_HIGH, PRIO_HIGH, PRIO_HIGH,
      PRIO_MEDIUM, PRIO_MEDIUM, PRIO_MEDIUM,
      PRIO_LOW, PRIO_LOW, PRIO_LOW, PRIO_LOW
   };

   localparam logic [1:0] RULE_ACTION [RULE_COUNT] = '{
      ACTION_BOOST, ACTION_BOOST, ACTION_BOOST, ACTION_BOOST,
      ACTION_BOOST, ACTION_BOOST, ACTION_BOOST, ACTION_BOOST,
      ACTION_BOOST, ACTION_BOOST, ACTION_BOOST, ACTION_BOOST,
      ACTION_BOOST, ACTION_BOOST, ACTION_BOOST,
      ACTION_OBSERVE, ACTION_OBSERVE, ACTION_THROTTLE, ACTION_THROTTLE
   };

   localparam logic [5:0] RULE_DSCP [RULE_COUNT] = '{
      DSCP_EF, DSCP_EF, DSCP_EF, DSCP_EF,
      DSCP_AF41, DSCP_AF41, DSCP_AF41, DSCP_AF41,
      DSCP_CS6, DSCP_CS6, DSCP_CS6, DSCP_CS6,
      DSCP_AF21, DSCP_AF21, DSCP_AF21,
      DSCP_CS2, DSCP_CS2, DSCP_CS1, DSCP_CS1
   };

   localparam logic [6:0] RULE_CONF [RULE_COUNT] = '{
      7'd92, 7'd90, 7'd88, 7'd86, 7'd82, 7'd80, 7'd83, 7'd81, 7'd86, 7'd86,
      7'd87, 7'd85, 7'd75, 7'd74, 7'd76, 7'd60, 7'd60, 7'd62, 7'd65
   };

   // ASCII upper case to lower case, everything else unchanged
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

### rtl/multi_pattern_signature_matcher.sv
// Top level of the multi-pattern signature matcher: shift-and rule engines and result buffer.
`timescale 1ns / 1ps

//  channel   ports                          direction   transaction
//  req       req_valid req_stall req_data   in          one text byte and/or end marks
//  rsp       rsp_valid rsp_stall rsp_data   out         one match result per request end
//
//  One req transaction per cycle while req_stall is low; every rule compares
//  the byte in parallel and its progress vector and hit flag update at the accepting edge.
//  A result is registered into output or skid at the edge that accepts its
//  request-end transaction. A two-entry buffer (output + skid) holds
//  results under rsp_stall; req_stall rises only once the skid entry is full.
//  Synchronous active-high reset clears progress vectors, hit flags and buffer.

module multi_pattern_signature_matcher
   import mpsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [MAX_PATTERN_LEN-1:0] progress_ff [RULE_COUNT];
   logic [MAX_PATTERN_LEN-1:0] progress_in [RULE_COUNT];
   logic [RULE_COUNT-1:0]      hit_ff;
   logic [RULE_COUNT-1:0]      hit_in;
   logic [RULE_COUNT-1:0]      flags_now;

   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   logic    accept;
   logic    out_take;
   logic    produce;
   logic    clear_prog;
   logic [7:0] ch;
   rsp_type result;

   assign req_stall  = skid_valid_ff;
   assign accept     = req_valid && !req_stall;
   assign out_take   = out_valid_ff && !rsp_stall;
   assign produce    = accept && req_data.request_end;
   assign clear_prog = req_data.field_end || req_data.request_end;
   assign ch         = fold_case(req_data.text_byte);

   // shift-and step per rule; only bytes of the rule's kind advance it
   always_comb begin
      logic [MAX_PATTERN_LEN-1:0] eq;
      logic [MAX_PATTERN_LEN-1:0] step;
      for (int r = 0; r < RULE_COUNT; r++) begin
         eq   = '0;
         step = progress_ff[r];
         flags_now[r] = hit_ff[r];
         for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            eq[i] = (RULE_TEXT[r][i] == ch) && (PAT_LEN_W'(i) < RULE_LEN[r]);
         end
         if (req_data.byte_valid && (req_data.kind == RULE_KIND[r]) &&
             (RULE_LEN[r] != '0) && (RULE_LEN[r] <= PAT_LEN_W'(MAX_PATTERN_LEN))) begin
            step = {progress_ff[r][MAX_PATTERN_LEN-2:0], 1'b1} & eq;
            if (step[PAT_IDX_W'(RULE_LEN[r] - PAT_LEN_W'(1))]) begin
               flags_now[r] = 1'b1;
            end
         end
         progress_in[r] = clear_prog ? '0 : step;
      end
      hit_in = req_data.request_end ? '0 : flags_now;
   end

   // lowest-numbered rule whose flag is set wins
   always_comb begin
      result = '0;
      for (int r = RULE_COUNT - 1; r >= 0; r--) begin
         if (flags_now[r]) begin
            result.matched        = 1'b1;
            result.rule_index     = RULE_IDX_W'(r);
            result.persona_code   = RULE_PERSONA[r];
            result.priority_code  = RULE_PRIO[r];
            result.action_code    = RULE_ACTION[r];
            result.dscp_value     = RULE_DSCP[r];
            result.confidence_pct = RULE_CONF[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < RULE_COUNT; r++) begin
            progress_ff[r] <= '0;
         end
         hit_ff <= '0;
      end else if (accept) begin
         progress_ff <= progress_in;
         hit_ff      <= hit_in;
      end
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_ff <= produce;
      end else if (produce) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || out_take) begin
         if (produce) begin
            out_data_ff <= result;
         end
      end else if (produce) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### tb/multi_pattern_signature_matcher_tb.sv
// Self-checking testbench for the signature matcher: directed and random hint streams vs. a shift-and predictor.
`timescale 1ns / 1ps

module multi_pattern_signature_matcher_tb;
   import mpsm_pkg::*;

   localparam int RANDOM_ITEMS = 1900;  // live transactions in the random phase
   localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction before giving up
   localparam int REPORT_MAX   = 10;    // mismatches printed in full
   localparam int SETTLE       = 8;     // cycles waited after the last owed verdict is checked

   // kinds that own no rule; 5..7 are outside the defined range
   localparam logic [2:0] KIND_SPARE = 3'd5;
   localparam logic [2:0] KIND_TOP   = 3'd7;

   // -------------------------------------------------------------------------
   // Verdict scoreboard: mirrors the rule engines and queues the verdict owed
   // for every accepted request end.
   // -------------------------------------------------------------------------
   class verdict_board;
      logic [2:0]                 rule_kind    [RULE_COUNT];
      int                         rule_len     [RULE_COUNT];
      logic [2:0]                 rule_persona [RULE_COUNT];
      logic [1:0]                 rule_prio    [RULE_COUNT];
      logic [1:0]                 rule_action  [RULE_COUNT];
      logic [5:0]                 rule_dscp    [RULE_COUNT];
      logic [6:0]                 rule_conf    [RULE_COUNT];
      logic [MAX_PATTERN_LEN-1:0] progress     [RULE_COUNT];
      logic [RULE_COUNT-1:0]      hit_flags;
      logic [RULE_COUNT-1:0]      rules_seen;
      rsp_type                    pending_verdicts [$];
      int                         failures;
      int                         requests_in;
      int                         hits_in;
      int                         verdicts_checked;

      function new();
         rule_kind = '{KIND_SNI, KIND_SNI, KIND_SNI, KIND_JA3, KIND_SNI, KIND_SNI,
                       KIND_SNI, KIND_SERVICE, KIND_SNI, KIND_SNI, KIND_APP, KIND_SNI,
                       KIND_SNI, KIND_SERVICE, KIND_SERVICE, KIND_SNI, KIND_SNI,
                       KIND_SNI, KIND_SERVICE};
         rule_len = '{7, 15, 11, 15, 11, 10, 7, 6, 3, 8, 8, 9, 13, 9, 3, 8, 11, 12, 6};
         rule_persona = '{PERSONA_VOIP, PERSONA_VOIP, PERSONA_VOIP, PERSONA_VOIP,
                          PERSONA_STREAMING, PERSONA_STREAMING, PERSONA_STREAMING,
                          PERSONA_STREAMING, PERSONA_GAMING, PERSONA_GAMING,
                          PERSONA_GAMING, PERSONA_GAMING, PERSONA_WORK, PERSONA_WORK,
                          PERSONA_WORK, PERSONA_IOT, PERSONA_IOT, PERSONA_BULK,
                          PERSONA_BULK};
         rule_prio = '{PRIO_HIGH, PRIO_HIGH, PRIO_HIGH, PRIO_HIGH,
                       PRIO_MEDIUM, PRIO_MEDIUM, PRIO_MEDIUM, PRIO_MEDIUM,
                       PRIO_HIGH, PRIO_HIGH, PRIO_HIGH, PRIO_HIGH,
                       PRIO_MEDIUM, PRIO_MEDIUM, PRIO_MEDIUM,
                       PRIO_LOW, PRIO_LOW, PRIO_LOW, PRIO_LOW};
         rule_action = '{ACTION_BOOST, ACTION_BOOST, ACTION_BOOST, ACTION_BOOST,
                         ACTION_BOOST, ACTION_BOOST, ACTION_BOOST, ACTION_BOOST,
                         ACTION_BOOST, ACTION_BOOST, ACTION_BOOST, ACTION_BOOST,
                         ACTION_BOOST, ACTION_BOOST, ACTION_BOOST,
                         ACTION_OBSERVE, ACTION_OBSERVE,
                         ACTION_THROTTLE, ACTION_THROTTLE};
         rule_dscp = '{DSCP_EF, DSCP_EF, DSCP_EF, DSCP_EF,
                       DSCP_AF41, DSCP_AF41, DSCP_AF41, DSCP_AF41,
                       DSCP_CS6, DSCP_CS6, DSCP_CS6, DSCP_CS6,
                       DSCP_AF21, DSCP_AF21, DSCP_AF21,
                       DSCP_CS2, DSCP_CS2, DSCP_CS1, DSCP_CS1};
         rule_conf = '{7'd92, 7'd90, 7'd88, 7'd86, 7'd82, 7'd80, 7'd83, 7'd81, 7'd86,
                       7'd86, 7'd87, 7'd85, 7'd75, 7'd74, 7'd76, 7'd60, 7'd60, 7'd62,
                       7'd65};
         for (int r = 0; r < RULE_COUNT; r++) begin
            progress[r] = '0;
         end
         hit_flags  = '0;
         rules_seen = '0;
      endfunction

      static function logic [7:0] lower_ascii(logic [7:0] c);
         return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
      endfunction

      static function string show(rsp_type v);
         return $sformatf("matched=%0d rule=%0d persona=%0d prio=%0d action=%0d dscp=%0d conf=%0d",
                          v.matched, v.rule_index, v.persona_code, v.priority_code,
                          v.action_code, v.dscp_value, v.confidence_pct);
      endfunction

      // one accepted request-side transaction
      function void note_req(req_type t);
         logic [7:0]                 ch;
         logic [MAX_PATTERN_LEN-1:0] eq;
         rsp_type                    v;
         ch = lower_ascii(t.text_byte);
         // byte first, marks after: a pattern finished by this byte still counts
         if (t.byte_valid) begin
            for (int r = 0; r < RULE_COUNT; r++) begin
               if (rule_kind[r] == t.kind) begin
                  eq = '0;
                  for (int i = 0; i < rule_len[r]; i++) begin
                     if (lower_ascii(RULE_TEXT[r][i]) == ch) begin
                        eq[i] = 1'b1;
                     end
                  end
                  progress[r] = ((progress[r] << 1) | 1'b1) & eq;
                  if (progress[r][rule_len[r] - 1]) begin
                     hit_flags[r] = 1'b1;
                  end
               end
            end
         end
         if (t.field_end || t.request_end) begin
            for (int r = 0; r < RULE_COUNT; r++) begin
               progress[r] = '0;
            end
         end
         if (t.request_end) begin
            v = '0;
            // walk downward so the lowest-numbered hit wins
            for (int r = RULE_COUNT - 1; r >= 0; r--) begin
               if (hit_flags[r]) begin
                  v.matched        = 1'b1;
                  v.rule_index     = RULE_IDX_W'(r);
                  v.persona_code   = rule_persona[r];
                  v.priority_code  = rule_prio[r];
                  v.action_code    = rule_action[r];
                  v.dscp_value     = rule_dscp[r];
                  v.confidence_pct = rule_conf[r];
               end
            end
            if (v.matched) begin
               hits_in++;
               rules_seen[v.rule_index] = 1'b1;
            end
            requests_in++;
            hit_flags = '0;
            pending_verdicts.push_back(v);
         end
      endfunction

      // one accepted result transaction
      function void check_rsp(rsp_type got);
         rsp_type want;
         bit      bad;
         if (pending_verdicts.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("%0t: unexpected result: %s", $time, show(got));
            end
            return;
         end
         want = pending_verdicts.pop_front();
         verdicts_checked++;
         bad = (got.matched !== want.matched) || (got.rule_index !== want.rule_index)
            || (got.persona_code !== want.persona_code)
            || (got.priority_code !== want.priority_code)
            || (got.action_code !== want.action_code)
            || (got.dscp_value !== want.dscp_value)
            || (got.confidence_pct !== want.confidence_pct);
         if (bad) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("%0t: verdict %0d mismatch", $time, verdicts_checked);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT, signals
   // -------------------------------------------------------------------------
   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   verdict_board board = new();

   bit req_calm;      // stretches with no gaps on the request side
   bit rsp_calm;      // stretches with no stalls on the result side
   int live_items;    // transactions that carry a byte or a mark
   int quiet_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   multi_pattern_signature_matcher uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Monitors sample pre-edge values at the rising edge, so the order of
   // events inside the step does not matter. The result of a request end is
   // registered at the edge that accepts it and is checked at a later edge,
   // hence the note always lands before the matching check.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         board.note_req(req_data);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_rsp(rsp_data);
      end
   end

   // Watchdog: any accepted transaction on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d verdicts still owed",
                  $time, quiet_cycles, board.pending_verdicts.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: per result, hold stall for a random gap, then release and
   // wait for the transaction to go through. Stall is asserted regardless of
   // rsp_valid, so it also lands while the block is idle or mid-request.
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 47) == 0) begin
            rsp_calm = !rsp_calm;
         end
         gap = rsp_calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // -------------------------------------------------------------------------
   // Request-side drivers
   // -------------------------------------------------------------------------

   // One transaction: optional gap with valid low, then hold the payload until
   // an edge sees valid high and stall low. Valid stays high into the next
   // call, so back-to-back transactions need no second assignment per step.
   task automatic push_req(input logic [2:0] kind, input logic [7:0] text_byte,
                           input logic byte_valid, input logic field_end,
                           input logic request_end);
      req_type t;
      int      gap;
      t.kind        = kind;
      t.text_byte   = text_byte;
      t.byte_valid  = byte_valid;
      t.field_end   = field_end;
      t.request_end = request_end;
      if ($urandom_range(0, 47) == 0) begin
         req_calm = !req_calm;
      end
      gap = req_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      if (byte_valid || field_end || request_end) begin
         live_items++;
      end
   endtask

   // a short string; marks ride on the last byte
   task automatic send_text(input logic [2:0] kind, input string s,
                            input logic field_end, input logic request_end);
      for (int i = 0; i < s.len(); i++) begin
         push_req(kind, s[i], 1'b1, field_end && i == s.len() - 1,
                  request_end && i == s.len() - 1);
      end
   endtask

   // half the time a character some rule uses, else any byte
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, RULE_COUNT - 1);
      if ($urandom_range(0, 1) == 0) begin
         return RULE_TEXT[r][$urandom_range(0, RULE_LEN[r] - 1)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // One field: mostly a rule pattern in mixed case with junk around it,
   // sometimes cut short or with one byte spoiled, sometimes pure junk.
   // The closing marks ride either on the last byte or on a marker-only item.
   task automatic send_field(input logic closes);
      logic [7:0] text [$];
      logic [7:0] c;
      logic [2:0] kind;
      logic       fe;
      logic       last;
      bit         marks_on_byte;
      int         r;
      int         n;
      r    = $urandom_range(0, RULE_COUNT - 1);
      kind = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : RULE_KIND[r];
      repeat ($urandom_range(0, 3)) text.push_back(pick_char());
      if ($urandom_range(0, 4) != 0) begin
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, RULE_LEN[r]) : RULE_LEN[r];
         for (int i = 0; i < n; i++) begin
            c = RULE_TEXT[r][i];
            if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 2) == 0) begin
               c = c - 8'h20;
            end
            text.push_back(c);
         end
         if ($urandom_range(0, 7) == 0) begin
            text[$urandom_range(0, text.size() - 1)] = pick_char();
         end
      end else begin
         repeat ($urandom_range(1, 12)) text.push_back(pick_char());
      end
      repeat ($urandom_range(0, 2)) text.push_back(pick_char());

      // a request may end without its last field being closed
      fe            = closes ? 1'($urandom_range(0, 1)) : 1'b1;
      marks_on_byte = 1'($urandom_range(0, 1));
      for (int i = 0; i < text.size(); i++) begin
         if ($urandom_range(0, 15) == 0) begin
            // no byte, no marks: must leave every vector alone
            push_req(3'($urandom_range(0, 7)), pick_char(), 1'b0, 1'b0, 1'b0);
         end
         last = (i == text.size() - 1) && marks_on_byte;
         push_req(kind, text[i], 1'b1, last && fe, last && closes);
      end
      if (!marks_on_byte) begin
         push_req(3'($urandom_range(0, 7)), pick_char(), 1'b0, fe, closes);
      end
   endtask

   // fully random transactions, marks included
   task automatic send_noise();
      repeat ($urandom_range(1, 8)) begin
         push_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 3) == 0));
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int fields;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // request end alone: no-match verdict, all class fields zero
      push_req(KIND_TOP, 8'hff, 1'b0, 1'b0, 1'b1);
      // field extremes on kinds with no rules, then close the request
      push_req(KIND_DNS, 8'h00, 1'b1, 1'b0, 1'b0);
      push_req(KIND_SPARE, 8'hff, 1'b1, 1'b1, 1'b0);
      push_req(KIND_TOP, 8'h00, 1'b0, 1'b0, 1'b1);
      // mixed case, and the last byte carries both marks: still a hit
      send_text(KIND_SNI, "PsN", 1'b1, 1'b1);
      // field end in the middle of a pattern breaks it
      send_text(KIND_SERVICE, "vP", 1'b1, 1'b0);
      send_text(KIND_SERVICE, "n", 1'b0, 1'b0);
      push_req(KIND_SNI, 8'h55, 1'b0, 1'b0, 1'b1);
      // request end without field end also clears progress
      send_text(KIND_SNI, "pS", 1'b0, 1'b1);
      send_text(KIND_SNI, "n", 1'b0, 1'b1);
      // right text, out-of-range kind
      send_text(KIND_TOP, "vpn", 1'b0, 1'b1);
      // hit, then marker-only field end and request end
      send_text(KIND_SERVICE, "VPN", 1'b0, 1'b0);
      push_req(KIND_APP, 8'ha5, 1'b0, 1'b1, 1'b0);
      push_req(KIND_SPARE, 8'h5a, 1'b0, 1'b0, 1'b1);
      // two rules hit in one request: lower index wins
      send_text(KIND_SNI, "psn", 1'b1, 1'b0);
      send_text(KIND_SERVICE, "vpn", 1'b0, 1'b1);

      // --- random: well-formed requests with some noise ---
      live_items = 0;
      while (live_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            send_noise();
         end else begin
            fields = $urandom_range(1, 3);
            for (int f = 0; f < fields; f++) begin
               send_field(f == fields - 1);
            end
         end
      end
      req_valid <= 1'b0;

      // drain; the watchdog covers a verdict that never shows
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Run covered %0d request ends (%0d with a rule hit), %0d of %0d rules hit",
               board.requests_in, board.hits_in, $countones(board.rules_seen), RULE_COUNT);
      $display("%0d verdicts checked, %0d failures", board.verdicts_checked, board.failures);
      if (board.failures == 0 && board.pending_verdicts.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### multi_pattern_signature_matcher.f
rtl/mpsm_pkg.sv
rtl/multi_pattern_signature_matcher.sv
tb/multi_pattern_signature_matcher_tb.sv
